>>> hdl/skt_pkg.sv
// Shared types and codes for the sorted key table.
`default_nettype none
package skt_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 40;
  localparam int SLOT_W = 7;
  localparam int CNT_W = 8;
  localparam int STAT_W = 3;
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NOP    = 2'd3
  } skt_cmd_t;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } skt_ctrl_t;

endpackage
`default_nettype wire

>>> hdl/skt_cell.sv
// One table slot: holds a key and value, compares against the broadcast key, shifts.
`default_nettype none
module skt_cell
  import skt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire skt_ctrl_t               ctrl,
  input  wire logic                    occ,
  input  wire logic signed [KEY_W-1:0] cmd_key,
  input  wire logic signed [VAL_W-1:0] cmd_value,
  input  wire logic                    prev_lt,
  input  wire logic signed [KEY_W-1:0] prev_key,
  input  wire logic signed [VAL_W-1:0] prev_value,
  input  wire logic signed [KEY_W-1:0] next_key,
  input  wire logic signed [VAL_W-1:0] next_value,
  output logic                         lt,
  output logic                         eq,
  output logic signed [KEY_W-1:0]      key,
  output logic signed [VAL_W-1:0]      value
);

  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= 1'b0;
      eq <= 1'b0;
    end else if (ctrl.cmp) begin
      lt <= occ && (key < cmd_key);
      eq <= occ && (key == cmd_key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      if (prev_lt) begin
        key   <= cmd_key;
        value <= cmd_value;
      end else begin
        key   <= prev_key;
        value <= prev_value;
      end
    end else if (ctrl.del && !lt) begin
      key   <= next_key;
      value <= next_value;
    end
  end

endmodule
`default_nettype wire

>>> hdl/sorted_key_table.sv
// Sorted key table: a chain of compare-and-shift cells with a command sequencer.
// An accepted command is registered, compared in the cell chain, then shifted and reported.
// A new command is taken only while idle or as the last result commits, not during
//   the compare step of the cell chain that comes before the shift step.
// Reset clears the entry count, sequencer, output valid and cell compare flags; cell keys
//   and values are not cleared and only slots below the entry count are ever used.
`default_nettype none
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // command[1:0], key[33:2], entry_value[73:34]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata    // status[2:0], slot[9:3], found_value[49:10],
                                                // entry_count[57:50]
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  state_t                  state;
  logic [1:0]              cmd;
  logic signed [KEY_W-1:0] cmd_key;
  logic signed [VAL_W-1:0] cmd_value;
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;

  skt_ctrl_t               ctrl;
  logic                    commit;
  logic                    accept;
  logic                    full;
  logic                    hit;

  logic [DEPTH-1:0]        lt;
  logic [DEPTH-1:0]        eq;
  logic [DEPTH-1:0]        first_ge;
  logic [DEPTH-1:0]        occ;
  logic signed [KEY_W-1:0] key_q [DEPTH];
  logic signed [VAL_W-1:0] val_q [DEPTH];

  logic [SW-1:0]           pos;
  logic signed [VAL_W-1:0] hit_value;
  logic [STAT_W-1:0]       status;
  logic [SW+SLOT_W-1:0]    slot_wide;
  logic [SLOT_W-1:0]       slot;
  logic signed [VAL_W-1:0] found_value;
  logic [CW+CNT_W-1:0]     count_wide;

  assign commit   = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign s_tready = (state == S_IDLE) || commit;
  assign accept   = s_tvalid && s_tready;

  assign full = (count == CW'(DEPTH));
  assign hit  = |eq;

  assign ctrl.cmp = (state == S_CMP);
  assign ctrl.ins = commit && (cmd == CMD_INSERT) && !full && !hit;
  assign ctrl.del = commit && (cmd == CMD_DELETE) && hit;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    p_lt;
    logic signed [KEY_W-1:0] p_key;
    logic signed [VAL_W-1:0] p_val;
    logic signed [KEY_W-1:0] n_key;
    logic signed [VAL_W-1:0] n_val;

    assign occ[i] = (CW'(i) < count);

    if (i == 0) begin : g_head
      assign p_lt  = 1'b1;
      assign p_key = key_q[i];
      assign p_val = val_q[i];
    end else begin : g_body
      assign p_lt  = lt[i-1];
      assign p_key = key_q[i-1];
      assign p_val = val_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_key = key_q[i];
      assign n_val = val_q[i];
    end else begin : g_mid
      assign n_key = key_q[i+1];
      assign n_val = val_q[i+1];
    end

    assign first_ge[i] = !lt[i] && p_lt;

    skt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .occ        (occ[i]),
      .cmd_key    (cmd_key),
      .cmd_value  (cmd_value),
      .prev_lt    (p_lt),
      .prev_key   (p_key),
      .prev_value (p_val),
      .next_key   (n_key),
      .next_value (n_val),
      .lt         (lt[i]),
      .eq         (eq[i]),
      .key        (key_q[i]),
      .value      (val_q[i])
    );
  end

  always_comb begin
    pos       = '0;
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_ge[i]) begin
        pos = pos | SW'(i);
      end
      if (eq[i]) begin
        hit_value = hit_value | val_q[i];
      end
    end
  end

  always_comb begin
    status      = ST_OK;
    slot_wide   = '0;
    found_value = '0;
    count_next  = count;
    case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (hit) begin
          status = ST_DUP;
        end else begin
          slot_wide  = {{SLOT_W{1'b0}}, pos};
          count_next = count + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else if (!hit) begin
          status = ST_NOTFOUND;
        end else begin
          slot_wide  = {{SLOT_W{1'b0}}, pos};
          count_next = count - 1'b1;
        end
      end
      CMD_SEARCH: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else if (!hit) begin
          status = ST_NOTFOUND;
        end else begin
          slot_wide   = {{SLOT_W{1'b0}}, pos};
          found_value = hit_value;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign slot       = slot_wide[SLOT_W-1:0];
  assign count_wide = {{CNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (commit) begin
            count    <= count_next;
            m_tvalid <= 1'b1;
            state    <= accept ? S_CMP : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd       <= s_tdata[1:0];
      cmd_key   <= s_tdata[33:2];
      cmd_value <= s_tdata[73:34];
    end
    if (commit) begin
      m_tdata <= {6'b0, count_wide[CNT_W-1:0], found_value, slot, status};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("entry count exceeds table depth");

  assert property (@(posedge clk) disable iff (rst) state == S_CMP |-> !s_tready)
    else $error("input taken during compare cycle");

  assert property (@(posedge clk) disable iff (rst) commit |=> m_tvalid)
    else $error("result lost after commit");

  assert property (@(posedge clk) disable iff (rst) state == S_EXEC |-> $onehot0(first_ge))
    else $error("table order broken: more than one insert boundary");

  assert property (@(posedge clk) disable iff (rst) state == S_EXEC |-> $onehot0(eq))
    else $error("key held in more than one slot");

endmodule
`default_nettype wire
